FILE: hdl/lars_pkg.sv
package lars_pkg;

  // Configuration register indexes
  localparam logic [0:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [0:0] REG_GRID_HEIGHT = 1'b1;

  localparam int GW_BITS  = 12;  // grid_width register bits
  localparam int GH_BITS  = 16;  // grid_height register bits
  localparam int CFG_BITS = 16;  // config data bits (widest register)
  localparam int MIN_DIM  = 3;   // smallest legal width and height

  // B3/S23
  localparam logic [3:0] RULE_BIRTH        = 4'd3;
  localparam logic [3:0] RULE_SURVIVE_LO   = 4'd2;
  localparam logic [3:0] RULE_SURVIVE_HI_X = 4'd4;

  // One window column: bit0 top, bit1 middle, bit2 bottom
  typedef logic [2:0] col_t;
  typedef logic [1:0] pop_t;

endpackage

FILE: hdl/lars_cell.sv
module lars_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  logic              shift,
  input  lars_pkg::col_t    d,
  output lars_pkg::col_t    q,
  output lars_pkg::pop_t    pop
);

  lars_pkg::col_t col_r;
  lars_pkg::col_t col_nxt;

  always_comb begin
    col_nxt = col_r;
    if (clr) begin
      col_nxt = '0;
    end else if (shift) begin
      col_nxt = d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  assign q   = col_r;
  // live cells in this column
  assign pop = 2'(col_r[0]) + 2'(col_r[1]) + 2'(col_r[2]);

endmodule

FILE: hdl/lars_line_buf.sv
module lars_line_buf #(
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [1:0]               wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [1:0]               rd_data
);

  // bit0: row r-2, bit1: row r-1
  logic [1:0] mem [DEPTH];
  logic [1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/life_automaton_raster_step_core.sv
// Channel | Dir | Handshake          | Word
// --------+-----+--------------------+-----------------------------------
// in_     | in  | in_valid/in_ready  | in_cell_alive (raster order)
// out_    | out | out_valid/out_ready| out_next_alive, out_frame_last
// cfg_    | in  | cfg_wr_en          | cfg_index, cfg_wdata
//
// One cell word per cycle sustained while out_ready is high; a result
// passes the window stage and output register. The line store prefetches
// the next column. Reset (rst_n low, synchronous) clears positions,
// window and both pipeline valids; the line store holds no reset state.
// A stalled output holds its word; the window stage takes one more result,
// after that in_ready drops and follows out_ready until the output drains.
module life_automaton_raster_step_core #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cell_alive,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_next_alive,
  output logic                          out_frame_last,
  input  logic                          cfg_wr_en,
  input  logic [0:0]                    cfg_index,
  input  logic [lars_pkg::CFG_BITS-1:0] cfg_wdata
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int RST_W = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
  localparam logic [AW-1:0] RST_WLAST = AW'(RST_W - 1);
  localparam logic [lars_pkg::GH_BITS-1:0] RST_HLAST = 16'd2047;

  // ---------------------------------------------------------------
  // Configuration: keep last column / last row, already saturated
  // ---------------------------------------------------------------
  logic [AW-1:0]                  wlast_r, wlast_nxt;
  logic [lars_pkg::GH_BITS-1:0]   hlast_r, hlast_nxt;
  logic [lars_pkg::GW_BITS-1:0]   cfg_w;
  logic [lars_pkg::GH_BITS-1:0]   cfg_h;

  assign cfg_w = cfg_wdata[lars_pkg::GW_BITS-1:0];
  assign cfg_h = cfg_wdata[lars_pkg::GH_BITS-1:0];

  always_comb begin
    wlast_nxt = wlast_r;
    hlast_nxt = hlast_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        lars_pkg::REG_GRID_WIDTH: begin
          if (32'(cfg_w) < lars_pkg::MIN_DIM) begin
            wlast_nxt = AW'(lars_pkg::MIN_DIM - 1);
          end else if (32'(cfg_w) > MAX_WIDTH) begin
            wlast_nxt = AW'(MAX_WIDTH - 1);
          end else begin
            wlast_nxt = AW'(32'(cfg_w) - 32'd1);
          end
        end
        lars_pkg::REG_GRID_HEIGHT: begin
          if (32'(cfg_h) < lars_pkg::MIN_DIM) begin
            hlast_nxt = 16'(lars_pkg::MIN_DIM - 1);
          end else begin
            hlast_nxt = cfg_h - 16'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Handshake and raster position
  // ---------------------------------------------------------------
  logic          s1_valid_r, s1_valid_nxt;   // window holds an unsent result
  logic          s1_last_r, s1_last_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_next_r, out_next_nxt;
  logic          out_last_r, out_last_nxt;
  logic          s1_move;
  logic          accept;
  logic [AW-1:0] col_r, col_nxt;
  logic [lars_pkg::GH_BITS-1:0] row_r, row_nxt;
  logic          at_wlast;
  logic          at_hlast;
  logic          emit;

  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_move;
  assign accept   = in_valid && in_ready;

  assign at_wlast = (col_r == wlast_r);
  assign at_hlast = (row_r == hlast_r);
  // interior cell (r-1, c-1) completes when (r, c) arrives with r, c >= 2
  assign emit     = (row_r >= 16'd2) && (32'(col_r) >= 2);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_wr_en) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (at_wlast) begin
        col_nxt = '0;
        row_nxt = at_hlast ? '0 : row_r + 16'd1;
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end
  end

  // ---------------------------------------------------------------
  // Line store: {row r-1, row r-2} per column, read one column ahead
  // ---------------------------------------------------------------
  logic [1:0]      lb_rd;
  lars_pkg::col_t  col_in;

  lars_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (col_r),
    .wr_data ({in_cell_alive, lb_rd[1]}),
    .rd_addr (col_nxt),
    .rd_data (lb_rd)
  );

  assign col_in = {in_cell_alive, lb_rd[1], lb_rd[0]};

  // ---------------------------------------------------------------
  // 3x3 window: chain of column cells, newest enters cell 2
  // ---------------------------------------------------------------
  lars_pkg::col_t win_q [3];
  lars_pkg::pop_t win_pop [3];

  for (genvar i = 0; i < 3; i++) begin : g_win
    lars_pkg::col_t d;
    if (i == 2) begin : g_head
      assign d = col_in;
    end else begin : g_link
      assign d = win_q[i+1];
    end
    lars_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .clr   (cfg_wr_en),
      .shift (accept),
      .d     (d),
      .q     (win_q[i]),
      .pop   (win_pop[i])
    );
  end

  // ---------------------------------------------------------------
  // Rule evaluation into the output register
  // ---------------------------------------------------------------
  logic       center;
  logic [3:0] nsum;
  logic       rule_out;

  assign center = win_q[1][1];
  assign nsum   = 4'(win_pop[0]) + 4'(win_pop[2]) + 4'(win_pop[1]) - 4'(center);

  always_comb begin
    if (center) begin
      rule_out = (nsum >= lars_pkg::RULE_SURVIVE_LO) && (nsum < lars_pkg::RULE_SURVIVE_HI_X);
    end else begin
      rule_out = (nsum == lars_pkg::RULE_BIRTH);
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_last_nxt  = s1_last_r;
    if (cfg_wr_en) begin
      s1_valid_nxt = 1'b0;
    end else if (accept) begin
      s1_valid_nxt = emit;
      s1_last_nxt  = at_wlast && at_hlast;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_next_nxt  = out_next_r;
    out_last_nxt  = out_last_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
      out_next_nxt  = rule_out;
      out_last_nxt  = s1_last_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlast_r     <= RST_WLAST;
      hlast_r     <= RST_HLAST;
      col_r       <= '0;
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wlast_r     <= wlast_nxt;
      hlast_r     <= hlast_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_last_r  <= s1_last_nxt;
    out_next_r <= out_next_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_next_alive = out_next_r;
  assign out_frame_last = out_last_r;

endmodule

FILE: hdl/lars_check.sv
module lars_check (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_next_alive,
  input logic out_frame_last
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_alive)
                               && $stable(out_frame_last))
    else $error("output word changed while stalled");

  // empty output stage never blocks the input
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // a fresh output word follows an accepted input word through the window stage and the output register
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("output word without matching input word");

  // reset empties the output
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind life_automaton_raster_step_core lars_check u_lars_check (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_next_alive (out_next_alive),
  .out_frame_last (out_frame_last)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

// Raster-stream Life (B3/S23) step core: self-checking bench.
// Cell words go in one at a time; a local predictor tracks line stores,
// the 3x3 window and the raster position, and queues the next-generation
// word for every interior cell. Result words are checked in order.
module testbench;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 6;
  localparam int LINE_CELLS    = 2048;  // line store depth of the instance
  localparam int GAP_PCT       = 8;     // sender idle chance per cycle
  localparam int STALL_PCT     = 8;     // receiver stall chance per cycle
  localparam int SETTLE_CYCLES = 8;     // pipeline is two deep; pad a bit more
  localparam int QUIET_LIMIT   = 2000;  // cycles with no word moving anywhere
  localparam int RANDOM_CELLS  = 350;

  typedef struct packed {
    logic next_alive;
    logic frame_last;
  } gen_result_t;

  typedef logic [lars_pkg::CFG_BITS-1:0] cfg_word_t;

  // ---------------------------------------------------------------------
  // DUT hookup; every input has a known value from time zero
  // ---------------------------------------------------------------------
  logic                          clk            = 1'b0;
  logic                          rst_n          = 1'b0;
  logic                          in_valid       = 1'b0;
  logic                          in_ready;
  logic                          in_cell_alive  = 1'b0;
  logic                          out_valid;
  logic                          out_ready      = 1'b0;
  logic                          out_next_alive;
  logic                          out_frame_last;
  logic                          cfg_wr_en      = 1'b0;
  logic [0:0]                    cfg_index      = lars_pkg::REG_GRID_WIDTH;
  logic [lars_pkg::CFG_BITS-1:0] cfg_wdata      = '0;

  life_automaton_raster_step_core #(
    .MAX_WIDTH(LINE_CELLS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cell_alive (in_cell_alive),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_next_alive(out_next_alive),
    .out_frame_last(out_frame_last),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor state: raw register values, two line stores, window, position
  // ---------------------------------------------------------------------
  logic [lars_pkg::GW_BITS-1:0] width_reg;
  logic [lars_pkg::GH_BITS-1:0] height_reg;
  bit                 upper_row  [LINE_CELLS];   // row r-2
  bit                 middle_row [LINE_CELLS];   // row r-1
  lars_pkg::col_t     cell_window[3];            // [0] oldest column
  int unsigned        row_pos;
  int unsigned        col_pos;

  gen_result_t        pending_states[$];         // next-gen words still owed
  int                 error_count  = 0;
  int                 quiet_cycles = 0;
  bit                 calm         = 1'b0;       // no idling on either side

  // Width saturates to 3..line depth, height to at least 3
  function automatic int unsigned effective_width();
    if (width_reg < lars_pkg::MIN_DIM) return lars_pkg::MIN_DIM;
    if (width_reg > LINE_CELLS) return LINE_CELLS;
    return width_reg;
  endfunction

  function automatic int unsigned effective_height();
    if (height_reg < lars_pkg::MIN_DIM) return lars_pkg::MIN_DIM;
    return height_reg;
  endfunction

  function automatic void restart_frame();
    row_pos = 0;
    col_pos = 0;
    foreach (cell_window[i]) cell_window[i] = '0;
  endfunction

  function automatic void reset_model();
    width_reg  = 12'd2048;
    height_reg = 16'd2048;
    foreach (upper_row[i]) begin
      upper_row[i]  = 1'b0;
      middle_row[i] = 1'b0;
    end
    restart_frame();
  endfunction

  // One accepted cell word: shift it into the window, update the line
  // stores, and queue the result for interior cell (r-1, c-1) if there is one.
  function automatic void advance_generation(input logic alive_in);
    int unsigned    w, h, c, r, neighbours;
    lars_pkg::col_t column;
    gen_result_t    res;
    w = effective_width();
    h = effective_height();
    c = col_pos;
    r = row_pos;
    if (c >= w) c = w - 1;
    column = {alive_in, middle_row[c], upper_row[c]};
    cell_window[0] = cell_window[1];
    cell_window[1] = cell_window[2];
    cell_window[2] = column;
    upper_row[c]  = middle_row[c];
    middle_row[c] = alive_in;
    if (r >= 2 && c >= 2) begin
      neighbours = $countones(cell_window[0]) + $countones(cell_window[2])
                 + cell_window[1][0] + cell_window[1][2];
      if (cell_window[1][1])
        res.next_alive = (neighbours >= lars_pkg::RULE_SURVIVE_LO)
                         && (neighbours < lars_pkg::RULE_SURVIVE_HI_X);
      else
        res.next_alive = (neighbours == lars_pkg::RULE_BIRTH);
      res.frame_last = (r == h - 1) && (c == w - 1);
      pending_states.push_back(res);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  // ---------------------------------------------------------------------
  // Result side: ready changes on the falling edge, words checked on the
  // rising edge against the oldest queued expectation
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= STALL_PCT);
  end

  always @(posedge clk) begin
    gen_result_t exp_word;
    if (rst_n && out_valid && out_ready) begin
      if (pending_states.size() == 0) begin
        $error("unexpected result word: next_alive %0b frame_last %0b",
               out_next_alive, out_frame_last);
        error_count++;
      end else begin
        exp_word = pending_states.pop_front();
        if (out_next_alive !== exp_word.next_alive) begin
          $error("next_alive mismatch: expected %0b, actual %0b",
                 exp_word.next_alive, out_next_alive);
          error_count++;
        end
        if (out_frame_last !== exp_word.frame_last) begin
          $error("frame_last mismatch: expected %0b, actual %0b",
                 exp_word.frame_last, out_frame_last);
          error_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which no word moves on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers. Every task is entered and left at a falling edge.
  // ---------------------------------------------------------------------

  // Send one cell word; valid stays up on return so back-to-back words
  // need no extra assignment. Random idle cycles drop valid first.
  task automatic send_cell(input logic alive_in);
    if (!calm) begin
      while ($urandom_range(99) < GAP_PCT) begin
        in_valid      <= 1'b0;
        in_cell_alive <= $urandom_range(1);
        @(negedge clk);
      end
    end
    in_valid      <= 1'b1;
    in_cell_alive <= alive_in;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_generation(alive_in);
    @(negedge clk);
  endtask

  task automatic send_random_cells(input int unsigned count, input int unsigned density);
    repeat (count) send_cell($urandom_range(99) < density);
  endtask

  // Stop sending, wait for every owed word, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_states.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Only called on an idle block (after drain_results); restarts the frame
  task automatic write_reg(input logic [0:0] index,
                           input logic [lars_pkg::CFG_BITS-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    if (index == lars_pkg::REG_GRID_WIDTH)
      width_reg = value[lars_pkg::GW_BITS-1:0];
    else
      height_reg = value[lars_pkg::GH_BITS-1:0];
    restart_frame();
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_geometry(input logic [lars_pkg::CFG_BITS-1:0] w,
                              input logic [lars_pkg::CFG_BITS-1:0] h);
    drain_results();
    write_reg(lars_pkg::REG_GRID_WIDTH, w);
    write_reg(lars_pkg::REG_GRID_HEIGHT, h);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset geometry is 2048 x 2048: nothing comes out inside the first row
  task automatic test_reset_geometry();
    send_random_cells(40, 50);
  endtask

  // 3x3 frames, one interior cell each; bit i of a pattern is raster cell i
  task automatic test_rule_cases();
    logic [8:0] frames[4];
    frames[0] = 9'b000_000_111;  // dead center, three neighbours: birth
    frames[1] = 9'b000_010_111;  // live center, three: survives
    frames[2] = 9'b101_010_101;  // live center, four: overcrowded
    frames[3] = 9'b000_011_000;  // live center, one: lonely
    set_geometry(16'd3, 16'd3);
    for (int f = 0; f < 2; f++)
      for (int i = 0; i < 9; i++) send_cell(frames[f][i]);
    // Junk above the width field, and both dimensions below the minimum
    set_geometry(16'hF002, 16'd0);
    for (int f = 2; f < 4; f++)
      for (int i = 0; i < 9; i++) send_cell(frames[f][i]);
  endtask

  // Width register at its top saturates to the line depth: part of the
  // first row streamed, no word may come out
  task automatic test_widest_row();
    set_geometry(16'h0FFF, 16'd3);
    send_random_cells(64, 50);
  endtask

  // Height register at its top; only the first rows, the frame never ends
  task automatic test_tallest_column();
    set_geometry(16'd3, 16'hFFFF);
    send_random_cells(30, 60);
  endtask

  // A register write in the middle of a frame starts the next one afresh
  task automatic test_restart_mid_frame();
    set_geometry(16'd5, 16'd5);
    send_random_cells(13, 50);
    drain_results();
    write_reg(lars_pkg::REG_GRID_HEIGHT, 16'd5);
    send_random_cells(25, 50);
  endtask

  // Sender holds off mid-frame until every owed word has come back
  task automatic test_pause_mid_frame();
    set_geometry(16'd7, 16'd4);
    send_random_cells(14, 40);
    drain_results();
    send_random_cells(14 + 28, 40);
  endtask

  // Two full frames and part of a third streamed with no idling on either side
  task automatic test_steady_stream();
    set_geometry(16'd9, 16'd7);
    calm = 1'b1;
    send_random_cells(150, 50);
    drain_results();
    calm = 1'b0;
  endtask

  // Random geometry per phase: full frames back to back, then a partial
  // frame (only the top rows if taller than 16), cut short by the next register write
  task automatic test_random_boards();
    int unsigned sent, w_cfg, h_cfg, frame_cells, count, density;
    int unsigned density_pick[5];
    density_pick = '{15, 35, 50, 65, 85};
    sent = 0;
    while (sent < RANDOM_CELLS) begin
      case ($urandom_range(9))
        0:       w_cfg = $urandom_range(2);
        1:       w_cfg = $urandom_range(24, 13);
        default: w_cfg = $urandom_range(12, 3);
      endcase
      case ($urandom_range(9))
        0:       h_cfg = $urandom_range(2);
        1:       h_cfg = $urandom_range(65535, 1000);
        default: h_cfg = $urandom_range(8, 3);
      endcase
      set_geometry(cfg_word_t'(($urandom_range(15) << lars_pkg::GW_BITS) | w_cfg),
                   cfg_word_t'(h_cfg));
      density     = density_pick[$urandom_range(4)];
      frame_cells = effective_width() * effective_height();
      if (effective_height() > 16)
        count = effective_width() * $urandom_range(10, 3);
      else
        count = frame_cells * $urandom_range(3, 1) + $urandom_range(frame_cells - 1);
      if (count > RANDOM_CELLS - sent) count = RANDOM_CELLS - sent;
      send_random_cells(count, density);
      sent += count;
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    reset_model();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_geometry();
    test_rule_cases();
    test_widest_row();
    test_tallest_column();
    test_restart_mid_frame();
    test_pause_mid_frame();
    test_steady_stream();
    test_random_boards();
    drain_results();

    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
